// ----- hdl/ptc_pkg.sv -----
// Shared types and constants for the pan-tilt target centering block.
// No dependencies; imported by every module of the block.
package ptc_pkg;

    // image center and limits
    localparam logic [10:0] CX_MID      = 11'd320;
    localparam logic [9:0]  CY_MID      = 10'd240;
    localparam logic [18:0] MIN_AREA    = 19'd400;
    localparam logic [9:0]  YAW_MAX     = 10'd180;
    localparam logic [9:0]  PITCH_LOW   = 10'd40;
    localparam logic [9:0]  PITCH_HIGH  = 10'd120;
    localparam logic [2:0]  STEP_MAX    = 3'd4;

    // reset values
    localparam logic [7:0]  RST_PITCH   = 8'd70;
    localparam logic [7:0]  RST_YAW     = 8'd90;
    localparam logic [6:0]  RST_LIMIT   = 7'd50;
    localparam logic [15:0] RST_GAIN    = 16'd1311;

    // register indexes
    localparam logic [1:0]  REG_TRACK_EN   = 2'd0;
    localparam logic [1:0]  REG_GAIN_X     = 2'd1;
    localparam logic [1:0]  REG_GAIN_Y     = 2'd2;
    localparam logic [1:0]  REG_LOST_LIMIT = 2'd3;

    // item kinds after classification
    localparam logic [1:0]  KIND_IGNORE = 2'd0;
    localparam logic [1:0]  KIND_FRAME  = 2'd1;
    localparam logic [1:0]  KIND_REPORT = 2'd2;

    // op codes on the input stream
    localparam logic        OP_FRAME  = 1'b0;
    localparam logic        OP_REPORT = 1'b1;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        track_en;
        logic [15:0] gain_x;
        logic [15:0] gain_y;
        logic [6:0]  lost_limit;
    } t_cfg;

    // classified item handed to the back end
    typedef struct packed {
        logic [1:0]  kind;
        logic        found;
        logic        low_area;
        logic        in_band;
        logic [3:0]  step_x;
        logic [3:0]  step_y;
        logic [7:0]  rep_pitch;
        logic [7:0]  rep_yaw;
    } t_work;

    typedef struct packed {
        logic        command_valid;
        logic [7:0]  pitch_command;
        logic [7:0]  yaw_command;
        logic        centred;
        logic        out_of_range;
        logic        lost;
        logic        too_small;
        logic        tracking;
    } t_res;

endpackage

// ----- hdl/pan_tilt_target_centering_top.sv -----
// An accepted input item is stored in the queue, then the back end executes it
// and registers the result item. Throughput: one item per cycle while the result
// stream is not stalled; the back-end held-state update is the loop that sets it.
// Reset: synchronous active-low; angles 70/90, countdown 50, tracking set,
// tracking mode off, gains 1311, queue and output register empty.
module pan_tilt_target_centering_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // found, center_x, center_y, box_area,
                                       // reported_pitch, reported_yaw, zero pad
    input  logic        s_axis_tuser,  // op
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // pitch_command, yaw_command, centred,
                                       // out_of_range, lost, too_small,
                                       // tracking, zero pad
    output logic        m_axis_tuser,  // command_valid
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptc_pkg::*;

    t_cfg  cfg;
    t_work work_in;
    t_work work_out;
    t_res  res;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;

    // configuration registers
    ptc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // front end classification
    ptc_front u_front (
        .i_cfg    (cfg),
        .i_op     (s_axis_tuser),
        .i_fields (s_axis_tdata[54:0]),
        .o_work   (work_in)
    );

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // queue between the two halves
    ptc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (work_in),
        .i_pop   (q_pop),
        .o_data  (work_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back end execution and result register
    ptc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_work  (work_out),
        .i_avail (!q_empty),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    // result packing
    assign m_axis_tuser = res.command_valid;
    assign m_axis_tdata = {3'd0, res.tracking, res.too_small, res.lost,
                           res.out_of_range, res.centred,
                           res.yaw_command, res.pitch_command};

endmodule

// ----- hdl/ptc_regs.sv -----
// Configuration register file behind an APB-style port.
// Depends on ptc_pkg.
module ptc_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output ptc_pkg::t_cfg    o_cfg
);
    import ptc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.track_en   <= 1'b0;
            r_cfg.gain_x     <= RST_GAIN;
            r_cfg.gain_y     <= RST_GAIN;
            r_cfg.lost_limit <= RST_LIMIT;
        end else if (wr_en) begin
            case (idx)
                REG_TRACK_EN:   r_cfg.track_en   <= pwdata[0];
                REG_GAIN_X:     r_cfg.gain_x     <= pwdata[15:0];
                REG_GAIN_Y:     r_cfg.gain_y     <= pwdata[15:0];
                REG_LOST_LIMIT: r_cfg.lost_limit <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (idx)
            REG_TRACK_EN:   prdata = {31'd0, r_cfg.track_en};
            REG_GAIN_X:     prdata = {16'd0, r_cfg.gain_x};
            REG_GAIN_Y:     prdata = {16'd0, r_cfg.gain_y};
            REG_LOST_LIMIT: prdata = {25'd0, r_cfg.lost_limit};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/ptc_front.sv -----
// Front end: decodes an input item, scales the center offsets by the gains
// and classifies the item for the back end. Depends on ptc_pkg.
module ptc_front (
    input  ptc_pkg::t_cfg  i_cfg,
    input  logic           i_op,
    input  logic [54:0]    i_fields,
    output ptc_pkg::t_work o_work
);
    import ptc_pkg::*;

    logic        found;
    logic [9:0]  cx;
    logic [8:0]  cy;
    logic [18:0] area;
    logic [10:0] off_x;
    logic [9:0]  off_y;
    logic        neg_x;
    logic        neg_y;
    logic [9:0]  mag_x;
    logic [8:0]  mag_y;
    logic [25:0] prod_x;
    logic [24:0] prod_y;
    logic [9:0]  q_x;
    logic [8:0]  q_y;
    logic [2:0]  smag_x;
    logic [2:0]  smag_y;

    // field unpacking
    assign found = i_fields[0];
    assign cx    = i_fields[10:1];
    assign cy    = i_fields[19:11];
    assign area  = i_fields[38:20];

    // signed offsets and magnitudes
    assign off_x = {1'b0, cx} - CX_MID;
    assign off_y = {1'b0, cy} - CY_MID;
    assign neg_x = off_x[10];
    assign neg_y = off_y[9];
    always_comb begin
        logic [10:0] ax;
        logic [9:0]  ay;
        ax    = neg_x ? (11'd0 - off_x) : off_x;
        ay    = neg_y ? (10'd0 - off_y) : off_y;
        mag_x = ax[9:0];
        mag_y = ay[8:0];
    end

    // gain scaling, truncated toward zero
    assign prod_x = {16'd0, mag_x} * {10'd0, i_cfg.gain_x};
    assign prod_y = {16'd0, mag_y} * {9'd0, i_cfg.gain_y};
    assign q_x    = prod_x[25:16];
    assign q_y    = prod_y[24:16];

    // step clamp
    assign smag_x = (q_x > {7'd0, STEP_MAX}) ? STEP_MAX : q_x[2:0];
    assign smag_y = (q_y > {6'd0, STEP_MAX}) ? STEP_MAX : q_y[2:0];

    // classification
    always_comb begin
        if (i_op == OP_REPORT) begin
            o_work.kind = KIND_REPORT;
        end else if (i_cfg.track_en) begin
            o_work.kind = KIND_FRAME;
        end else begin
            o_work.kind = KIND_IGNORE;
        end
        o_work.found     = found;
        o_work.low_area  = area < MIN_AREA;
        o_work.in_band   = (q_x < 10'd2) && (q_y == 9'd0);
        o_work.step_x    = neg_x ? (4'd0 - {1'b0, smag_x}) : {1'b0, smag_x};
        o_work.step_y    = neg_y ? (4'd0 - {1'b0, smag_y}) : {1'b0, smag_y};
        o_work.rep_pitch = i_fields[46:39];
        o_work.rep_yaw   = i_fields[54:47];
    end

endmodule

// ----- hdl/ptc_queue.sv -----
// Short register queue of classified items between front and back end.
// Depends on ptc_pkg.
module ptc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptc_pkg::t_work i_data,
    input  logic           i_pop,
    output ptc_pkg::t_work o_data,
    output logic           o_full,
    output logic           o_empty
);
    import ptc_pkg::*;

    t_work             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // fill count stays within depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ----- hdl/ptc_back.sv -----
// Back end: holds servo angles, miss countdown and tracking flag, applies
// each classified item and registers the result item. Depends on ptc_pkg.
module ptc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptc_pkg::t_cfg  i_cfg,
    input  ptc_pkg::t_work i_work,
    input  logic           i_avail,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output ptc_pkg::t_res  o_res
);
    import ptc_pkg::*;

    logic [7:0] r_pitch;
    logic [7:0] r_yaw;
    logic [7:0] r_miss;
    logic       r_trk;
    logic       r_ovalid;
    t_res       r_res;

    logic [7:0] n_pitch;
    logic [7:0] n_yaw;
    logic [7:0] n_miss;
    logic       n_trk;
    t_res       n_res;

    logic [9:0] yaw_c;
    logic [9:0] pitch_c;
    logic       in_range;

    // output register frees when empty or taken
    assign o_pop = i_avail && (!r_ovalid || i_ready);

    // candidate angles and servo range check
    assign yaw_c    = {2'b00, r_yaw} - {{6{i_work.step_x[3]}}, i_work.step_x};
    assign pitch_c  = {2'b00, r_pitch} - {{6{i_work.step_y[3]}}, i_work.step_y};
    assign in_range = !yaw_c[9] && ($signed(yaw_c) <= $signed(YAW_MAX))
                   && ($signed(pitch_c) > $signed(PITCH_LOW))
                   && ($signed(pitch_c) < $signed(PITCH_HIGH));

    // item execution
    always_comb begin
        n_pitch = r_pitch;
        n_yaw   = r_yaw;
        n_miss  = r_miss;
        n_trk   = r_trk;
        n_res   = '0;
        case (i_work.kind)
            KIND_REPORT: begin
                n_pitch = i_work.rep_pitch;
                n_yaw   = i_work.rep_yaw;
            end
            KIND_FRAME: begin
                if (i_work.low_area) begin
                    n_res.too_small = 1'b1;
                    n_trk           = 1'b0;
                end
                if (i_work.found) begin
                    if (i_work.in_band) begin
                        n_res.centred = 1'b1;
                        n_trk         = 1'b1;
                        n_miss        = {1'b0, i_cfg.lost_limit};
                    end else if (in_range) begin
                        n_res.command_valid = 1'b1;
                        n_trk               = 1'b1;
                        n_miss              = {1'b0, i_cfg.lost_limit};
                        n_pitch             = pitch_c[7:0];
                        n_yaw               = yaw_c[7:0];
                    end else begin
                        n_res.out_of_range = 1'b1;
                        n_trk              = 1'b0;
                    end
                end else begin
                    // countdown saturates at minus one
                    if (!r_miss[7]) begin
                        n_miss = r_miss - 8'd1;
                    end
                    if (n_miss[7]) begin
                        n_trk = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        n_res.pitch_command = n_pitch;
        n_res.yaw_command   = n_yaw;
        n_res.lost          = n_miss[7];
        n_res.tracking      = n_trk;
    end

    // held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= RST_PITCH;
            r_yaw   <= RST_YAW;
            r_miss  <= {1'b0, RST_LIMIT};
            r_trk   <= 1'b1;
        end else if (o_pop) begin
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
            r_miss  <= n_miss;
            r_trk   <= n_trk;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_pop) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    // an issued command lies inside the servo range
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.command_valid |->
            r_res.yaw_command <= YAW_MAX[7:0] &&
            r_res.pitch_command > PITCH_LOW[7:0] &&
            r_res.pitch_command < PITCH_HIGH[7:0])
        else $error("command outside servo range");

    // centred, command and out of range exclude one another
    a_outcome_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> $countones({r_res.command_valid, r_res.centred,
                                 r_res.out_of_range}) <= 1)
        else $error("conflicting outcome flags");

    // a lost target is never tracked
    a_lost_untracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss[7] |-> !r_trk)
        else $error("tracking with expired countdown");
`endif

endmodule

// ----- tb/sv/tb_pan_tilt_target_centering_top.sv -----
// Self-checking testbench for pan_tilt_target_centering_top: sends frame and servo report
// items, predicts every result item in step and compares it field by field.
// Depends on ptc_pkg and the block's top level only.
module tb_pan_tilt_target_centering_top;
    import ptc_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 4;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // found, center_x, center_y, box_area,
                                       // reported_pitch, reported_yaw, zero pad
    logic        s_axis_tuser  = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;         // pitch_command, yaw_command, centred,
                                       // out_of_range, lost, too_small, tracking, zero pad
    logic        m_axis_tuser;         // command_valid
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // run control shared by the processes
    logic idle_on     = 1'b1;
    logic hold_req    = 1'b0;
    int   fail_count  = 0;
    int   quiet_cycles = 0;

    // predictor copy of configuration and state
    logic cfg_track_en   = 1'b0;
    int   cfg_gain_x     = int'(RST_GAIN);
    int   cfg_gain_y     = int'(RST_GAIN);
    int   cfg_lost_limit = int'(RST_LIMIT);
    int   held_pitch_deg = int'(RST_PITCH);
    int   held_yaw_deg   = int'(RST_YAW);
    int   miss_left      = int'(RST_LIMIT);
    logic track_flag     = 1'b1;

    t_res servo_results_due[$];

    pan_tilt_target_centering_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // pixel offset times q0.16 gain, truncated toward zero
    function automatic int scale_to_deg(input int off, input int gain);
        longint mag;
        int     q;
        mag = longint'((off < 0) ? -off : off);
        q   = int'((mag * gain) >> 16);
        return (off < 0) ? -q : q;
    endfunction

    function automatic int clamp_step(input int d);
        if (d < -int'(STEP_MAX)) return -int'(STEP_MAX);
        if (d > int'(STEP_MAX)) return int'(STEP_MAX);
        return d;
    endfunction

    // expected result of one item, advancing the predictor state
    function automatic t_res centering_predict(input logic op, input logic [55:0] d);
        t_res r;
        int   cx;
        int   cy;
        int   dx;
        int   dy;
        int   yaw;
        int   pitch;
        r  = '0;
        cx = int'(d[10:1]);
        cy = int'(d[19:11]);
        if (op == OP_REPORT) begin
            held_pitch_deg = int'(d[46:39]);
            held_yaw_deg   = int'(d[54:47]);
        end else if (cfg_track_en) begin
            if (d[38:20] < MIN_AREA) begin
                r.too_small = 1'b1;
                track_flag  = 1'b0;
            end
            if (d[0]) begin
                dx = scale_to_deg(cx - int'(CX_MID), cfg_gain_x);
                dy = scale_to_deg(cy - int'(CY_MID), cfg_gain_y);
                // deadband: under two degrees sideways, under one up or down
                if (dx > -2 && dx < 2 && dy == 0) begin
                    r.centred  = 1'b1;
                    track_flag = 1'b1;
                    miss_left  = cfg_lost_limit;
                end else begin
                    yaw   = held_yaw_deg - clamp_step(dx);
                    pitch = held_pitch_deg - clamp_step(dy);
                    if (yaw >= 0 && yaw <= int'(YAW_MAX) &&
                        pitch > int'(PITCH_LOW) && pitch < int'(PITCH_HIGH)) begin
                        r.command_valid = 1'b1;
                        track_flag      = 1'b1;
                        miss_left       = cfg_lost_limit;
                        held_pitch_deg  = pitch;
                        held_yaw_deg    = yaw;
                    end else begin
                        r.out_of_range = 1'b1;
                        track_flag     = 1'b0;
                    end
                end
            end else begin
                // miss countdown saturates at -1
                if (miss_left > -1) miss_left--;
                if (miss_left < 0) track_flag = 1'b0;
            end
        end
        r.pitch_command = 8'(held_pitch_deg);
        r.yaw_command   = 8'(held_yaw_deg);
        r.lost          = (miss_left < 0);
        r.tracking      = track_flag;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    // compare accepted result items, then predict accepted input items
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (servo_results_due.size() == 0) begin
                    $error("result item with no expectation pending");
                    fail_count++;
                end else begin
                    want = servo_results_due.pop_front();
                    check_field("command_valid", 32'(want.command_valid), 32'(m_axis_tuser));
                    check_field("pitch_command", 32'(want.pitch_command),
                                32'(m_axis_tdata[7:0]));
                    check_field("yaw_command", 32'(want.yaw_command), 32'(m_axis_tdata[15:8]));
                    check_field("centred", 32'(want.centred), 32'(m_axis_tdata[16]));
                    check_field("out_of_range", 32'(want.out_of_range), 32'(m_axis_tdata[17]));
                    check_field("lost", 32'(want.lost), 32'(m_axis_tdata[18]));
                    check_field("too_small", 32'(want.too_small), 32'(m_axis_tdata[19]));
                    check_field("tracking", 32'(want.tracking), 32'(m_axis_tdata[20]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                servo_results_due.insert(servo_results_due.size(),
                                         centering_predict(s_axis_tuser, s_axis_tdata));
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                n = 0;
                while (n < HOLD_OFF_CYCLES) begin
                    @(posedge i_clk);
                    n++;
                end
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [55:0] frame_item(input logic found, input int cx, input int cy,
                                               input int area);
        return {1'b0, 8'($urandom), 8'($urandom), 19'(area), 9'(cy), 10'(cx), found};
    endfunction

    function automatic logic [55:0] report_item(input int pitch, input int yaw);
        return {1'b0, 8'(yaw), 8'(pitch), 19'($urandom), 9'($urandom), 10'($urandom),
                1'($urandom)};
    endfunction

    // half the time near the image center, else anywhere in the image or the field
    function automatic int rand_coord(input int mid, input int top);
        case ($urandom_range(0, 7))
            0, 1, 2: return mid - 24 + int'($urandom_range(0, 48));
            3:       return mid - 3 + int'($urandom_range(0, 6));
            4, 5:    return int'($urandom_range(0, 2 * mid - 1));
            default: return int'($urandom_range(0, top));
        endcase
    endfunction

    function automatic int rand_area();
        case ($urandom_range(0, 9))
            0:       return int'($urandom_range(0, 399));
            1:       return int'($urandom_range(0, 524287));
            default: return int'($urandom_range(400, 307200));
        endcase
    endfunction

    // drive one item; valid stays high into the next item unless a gap is taken
    task automatic send_item(input logic op, input logic [55:0] d);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            if ($urandom_range(0, 7) == 0)
                send_item(OP_REPORT, report_item($urandom_range(0, 255), $urandom_range(0, 255)));
            else
                send_item(OP_REPORT, report_item($urandom_range(35, 125), $urandom_range(0, 185)));
        end else begin
            send_item(OP_FRAME, frame_item(pick > 2, rand_coord(320, 1023),
                                           rand_coord(240, 511), rand_area()));
        end
    endtask

    // stop sending and wait until every pending result has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (servo_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TRACK_EN:   cfg_track_en   = val[0];
            REG_GAIN_X:     cfg_gain_x     = int'(val[15:0]);
            REG_GAIN_Y:     cfg_gain_y     = int'(val[15:0]);
            REG_LOST_LIMIT: cfg_lost_limit = int'(val[6:0]);
            default: ;
        endcase
    endtask

    task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write all registers with junk in the unused bits, then read them back
    task automatic apply_setting(input logic en, input int gx, input int gy, input int lim);
        settle();
        reg_write(REG_TRACK_EN, {31'($urandom), en});
        reg_write(REG_GAIN_X, {16'($urandom), 16'(gx)});
        reg_write(REG_GAIN_Y, {16'($urandom), 16'(gy)});
        reg_write(REG_LOST_LIMIT, {25'($urandom), 7'(lim)});
        reg_check(REG_TRACK_EN, {31'b0, en});
        reg_check(REG_GAIN_X, {16'b0, 16'(gx)});
        reg_check(REG_GAIN_Y, {16'b0, 16'(gy)});
        reg_check(REG_LOST_LIMIT, {25'b0, 7'(lim)});
    endtask

    // reset register values, frames ignored with tracking off, reports still applied
    task automatic test_tracking_off();
        reg_check(REG_TRACK_EN, 32'd0);
        reg_check(REG_GAIN_X, {16'b0, RST_GAIN});
        reg_check(REG_GAIN_Y, {16'b0, RST_GAIN});
        reg_check(REG_LOST_LIMIT, {25'b0, RST_LIMIT});
        send_item(OP_FRAME, frame_item(1'b1, 100, 100, 1000));
        send_item(OP_FRAME, frame_item(1'b0, 320, 240, 0));
        send_item(OP_REPORT, report_item(0, 255));
        send_item(OP_REPORT, report_item(70, 90));
    endtask

    task automatic test_directed_cases();
        apply_setting(1'b1, 1311, 1311, 3);
        // centred, then field extremes and command steps
        send_item(OP_FRAME, frame_item(1'b1, 320, 240, 400));
        send_item(OP_FRAME, frame_item(1'b1, 0, 0, 307200));
        send_item(OP_FRAME, frame_item(1'b1, 1023, 511, 524287));
        // small box while found still commands
        send_item(OP_FRAME, frame_item(1'b1, 639, 479, 399));
        // misses run the countdown out and past it
        send_item(OP_FRAME, frame_item(1'b0, 320, 240, 399));
        repeat (4) send_item(OP_FRAME, frame_item(1'b0, 0, 0, 1000));
        send_item(OP_FRAME, frame_item(1'b1, 330, 245, 1000));
        // out of range on each servo limit
        send_item(OP_REPORT, report_item(41, 0));
        send_item(OP_FRAME, frame_item(1'b1, 320, 479, 1000));
        send_item(OP_FRAME, frame_item(1'b1, 639, 240, 1000));
        send_item(OP_REPORT, report_item(119, 180));
        send_item(OP_FRAME, frame_item(1'b1, 0, 240, 1000));
        send_item(OP_FRAME, frame_item(1'b1, 320, 0, 1000));
        // report outside the servo range is held as given
        send_item(OP_REPORT, report_item(255, 255));
        send_item(OP_FRAME, frame_item(1'b1, 320, 240, 1000));
        send_item(OP_FRAME, frame_item(1'b1, 400, 240, 1000));
        send_item(OP_FRAME, frame_item(1'b1, 420, 240, 1000));
        send_item(OP_REPORT, report_item(70, 90));
        // deadband edge in pitch
        send_item(OP_FRAME, frame_item(1'b1, 320, 241, 1000));
        send_item(OP_FRAME, frame_item(1'b1, 320, 290, 1000));
    endtask

    // result side holds off long enough for the block to fill and stall its input
    task automatic test_stall_recovery();
        apply_setting(1'b1, int'(RST_GAIN), int'(RST_GAIN), int'(RST_LIMIT));
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_random_item();
    endtask

    task automatic random_phase(input logic en, input int gx, input int gy, input int lim,
                                input logic idle, input int n);
        apply_setting(en, gx, gy, lim);
        idle_on = idle;
        repeat (n) send_random_item();
    endtask

    task automatic test_random_traffic();
        random_phase(1'b1, int'(RST_GAIN), int'(RST_GAIN), int'(RST_LIMIT), 1'b1, 120);
        random_phase(1'b1, 65535, 65535, 127, 1'b0, 100);
        random_phase(1'b1, 0, 0, 0, 1'b1, 60);
        random_phase(1'b1, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 7), 1'b1, 120);
        random_phase(1'b0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 127), 1'b1, 40);
        random_phase(1'b1, $urandom_range(4000, 20000), $urandom_range(4000, 20000),
                     $urandom_range(0, 15), 1'b1, 120);
        // closing stretch without idling
        random_phase(1'b1, int'(RST_GAIN), 2622, 5, 1'b0, 80);
    endtask

    initial begin : run
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tracking_off();
        test_directed_cases();
        test_stall_recovery();
        test_random_traffic();
        settle();
        if (fail_count == 0 && servo_results_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ptc_pkg.sv
hdl/ptc_regs.sv
hdl/ptc_front.sv
hdl/ptc_queue.sv
hdl/ptc_back.sv
hdl/pan_tilt_target_centering_top.sv
tb/sv/tb_pan_tilt_target_centering_top.sv
